// ----- src/lkpt_pkg.sv -----
`default_nettype none
package lkpt_pkg;

  localparam int SLOTS    = 8;
  localparam int LIST_MAX = 8;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W    = $clog2(SLOTS + LIST_MAX + 1);
  localparam int KEY_W    = 256;
  localparam int AUTH_W   = 8;
  localparam int REC_W    = 32;
  localparam int IN_W     = 264;
  localparam int OUT_W    = 304;

  typedef enum logic [1:0] {
    FUNC_RECORD  = 2'd0,
    FUNC_PROMOTE = 2'd1,
    FUNC_REMOVE  = 2'd2,
    FUNC_LIST    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_LCOUNT,
    S_LSEL,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic              done;
    logic [SLOT_W-1:0] slot;
    logic [REC_W-1:0]  rec;
    logic [AUTH_W-1:0] auth;
    logic [KEY_W-1:0]  key;
  } entry_t;

  typedef struct packed {
    status_t           status;
    logic [2:0]        slot;
    logic [KEY_W-1:0]  key;
    logic [AUTH_W-1:0] auth;
    logic [REC_W-1:0]  rec;
    logic              last;
  } result_t;

endpackage
`default_nettype wire

// ----- src/lkpt_cell.sv -----
`default_nettype none
module lkpt_cell (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire [lkpt_pkg::SLOT_W-1:0]   init_slot,
  input  wire                          shift_en,
  input  wire lkpt_pkg::entry_t        d_in,
  output lkpt_pkg::entry_t             q,
  output logic                         valid
);

  lkpt_pkg::entry_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.done <= 1'b0;
      q_r.slot <= init_slot;
      q_r.rec  <= '0;
      q_r.auth <= '0;
      q_r.key  <= '0;
    end else if (shift_en) begin
      q_r <= d_in;
    end
  end

  assign q     = q_r;
  assign valid = (q_r.key[7:0] != 8'd0);

endmodule
`default_nettype wire

// ----- src/lru_keyed_profile_table.sv -----
`default_nettype none
// Keyed table of lkpt_pkg::SLOTS entries held in a ring of cells that rotates
// one position per clock during each pass of a command, so slot 0 sits at the
// head at the start of every pass. With the output free: record, promote and
// remove go through acceptance, one search pass, one update pass and a handover
// of the result; a promote or remove whose key is not found skips the update
// pass and an invalid key skips both passes. List goes through acceptance, one
// counting pass, and then one selection pass plus one handover per listed
// entry; an empty table goes straight to the handover. Each handover stretches
// while out_tready holds the previous result. A new command is taken only once
// the previous one has placed its last result in the output register.
module lru_keyed_profile_table (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  // key_word0, key_word1, key_word2, key_word3, auth_mode
  input  wire [lkpt_pkg::IN_W-1:0]       in_tdata,
  // func
  input  wire [1:0]                      in_tuser,
  output logic                           out_tvalid,
  input  wire                            out_tready,
  // status, slot, out_key0, out_key1, out_key2, out_key3, out_auth, recency, zero pad
  output logic [lkpt_pkg::OUT_W-1:0]     out_tdata,
  output logic                           out_tlast
);

  function automatic logic [lkpt_pkg::KEY_W-1:0] normalize(
    input logic [lkpt_pkg::KEY_W-1:0] k
  );
    logic [lkpt_pkg::KEY_W-1:0] r;
    logic ended;
    r     = k;
    ended = 1'b0;
    for (int b = 0; b < 32; b++) begin
      if (ended) r[8*b +: 8] = 8'd0;
      else if (k[8*b +: 8] == 8'd0) ended = 1'b1;
    end
    return r;
  endfunction

  lkpt_pkg::entry_t ring_q [lkpt_pkg::SLOTS];
  logic             ring_v [lkpt_pkg::SLOTS];
  lkpt_pkg::entry_t wb;
  lkpt_pkg::entry_t head;
  logic             shift_en;

  lkpt_pkg::state_t  state_r, state_nxt;
  logic [lkpt_pkg::SLOT_W-1:0] pos_r, pos_nxt;
  lkpt_pkg::func_t   func_r, func_nxt;
  logic [lkpt_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [lkpt_pkg::AUTH_W-1:0] auth_r, auth_nxt;
  logic [lkpt_pkg::REC_W-1:0]  cnt_r, cnt_nxt;
  logic                        hit_r, hit_nxt;
  logic [lkpt_pkg::SLOT_W-1:0] hit_slot_r, hit_slot_nxt;
  logic [lkpt_pkg::AUTH_W-1:0] hit_auth_r, hit_auth_nxt;
  logic [lkpt_pkg::REC_W-1:0]  hit_rec_r, hit_rec_nxt;
  logic                        emp_r, emp_nxt;
  logic [lkpt_pkg::SLOT_W-1:0] emp_slot_r, emp_slot_nxt;
  logic [lkpt_pkg::SLOT_W-1:0] min_slot_r, min_slot_nxt;
  logic [lkpt_pkg::REC_W-1:0]  min_rec_r, min_rec_nxt;
  logic [lkpt_pkg::SLOT_W-1:0] tgt_r, tgt_nxt;
  logic [lkpt_pkg::CNT_W-1:0]  total_r, total_nxt;
  logic [lkpt_pkg::CNT_W-1:0]  lim_r, lim_nxt;
  logic [lkpt_pkg::CNT_W-1:0]  n_r, n_nxt;
  logic                        prev_v_r, prev_v_nxt;
  logic [lkpt_pkg::SLOT_W-1:0] prev_r, prev_nxt;
  logic                        best_v_r, best_v_nxt;
  lkpt_pkg::entry_t            best_r, best_nxt;
  lkpt_pkg::result_t           pend_r, pend_nxt;
  lkpt_pkg::result_t           out_r, out_nxt;
  logic                        out_v_r, out_v_nxt;

  logic in_acc, pass_end, out_free, head_valid, wb_valid, norm_ok;
  logic [lkpt_pkg::KEY_W-1:0] norm_key;

  genvar gi;
  generate
    for (gi = 0; gi < lkpt_pkg::SLOTS; gi++) begin : g_ring
      lkpt_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .init_slot(lkpt_pkg::SLOT_W'(gi)),
        .shift_en (shift_en),
        .d_in     ((gi == lkpt_pkg::SLOTS - 1) ? wb : ring_q[(gi + 1) % lkpt_pkg::SLOTS]),
        .q        (ring_q[gi]),
        .valid    (ring_v[gi])
      );
    end
  endgenerate

  assign head       = ring_q[0];
  assign head_valid = ring_v[0];
  assign wb_valid   = (wb.key[7:0] != 8'd0);
  assign in_tready  = (state_r == lkpt_pkg::S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign pass_end   = (pos_r == lkpt_pkg::SLOT_W'(lkpt_pkg::SLOTS - 1));
  assign out_free   = !out_v_r || out_tready;
  assign norm_key   = normalize(in_tdata[lkpt_pkg::KEY_W-1:0]);
  assign norm_ok    = (norm_key[7:0] != 8'd0);
  assign shift_en   = (state_r == lkpt_pkg::S_SCAN) || (state_r == lkpt_pkg::S_APPLY) ||
                      (state_r == lkpt_pkg::S_LCOUNT) || (state_r == lkpt_pkg::S_LSEL);

  // write-back into the tail of the ring
  always_comb begin
    wb = head;
    unique case (state_r)
      lkpt_pkg::S_APPLY: begin
        if (head.slot == tgt_r) begin
          case (func_r)
            lkpt_pkg::FUNC_RECORD: begin
              wb.key  = pend_r.key;
              wb.auth = pend_r.auth;
              wb.rec  = pend_r.rec;
            end
            lkpt_pkg::FUNC_PROMOTE: wb.rec = pend_r.rec;
            lkpt_pkg::FUNC_REMOVE: begin
              wb.key  = '0;
              wb.auth = '0;
              wb.rec  = '0;
            end
            default: wb = head;
          endcase
        end
      end
      lkpt_pkg::S_LCOUNT: wb.done = 1'b0;
      lkpt_pkg::S_LSEL: begin
        if (prev_v_r && head.slot == prev_r) wb.done = 1'b1;
      end
      default: wb = head;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lkpt_pkg::S_IDLE: begin
        if (in_acc) begin
          if (lkpt_pkg::func_t'(in_tuser) == lkpt_pkg::FUNC_LIST) state_nxt = lkpt_pkg::S_LCOUNT;
          else if (!norm_ok) state_nxt = lkpt_pkg::S_EMIT;
          else state_nxt = lkpt_pkg::S_SCAN;
        end
      end
      lkpt_pkg::S_SCAN: begin
        if (pass_end) begin
          if (func_r != lkpt_pkg::FUNC_RECORD && !hit_nxt) state_nxt = lkpt_pkg::S_EMIT;
          else state_nxt = lkpt_pkg::S_APPLY;
        end
      end
      lkpt_pkg::S_APPLY: if (pass_end) state_nxt = lkpt_pkg::S_EMIT;
      lkpt_pkg::S_LCOUNT: begin
        if (pass_end) state_nxt = (total_nxt == '0) ? lkpt_pkg::S_EMIT : lkpt_pkg::S_LSEL;
      end
      lkpt_pkg::S_LSEL: if (pass_end) state_nxt = lkpt_pkg::S_EMIT;
      lkpt_pkg::S_EMIT: begin
        if (out_free) state_nxt = pend_r.last ? lkpt_pkg::S_IDLE : lkpt_pkg::S_LSEL;
      end
      default: state_nxt = lkpt_pkg::S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    pos_nxt      = shift_en ? pos_r + 1'b1 : '0;
    if (shift_en && pass_end) pos_nxt = '0;
    func_nxt     = func_r;
    key_nxt      = key_r;
    auth_nxt     = auth_r;
    cnt_nxt      = cnt_r;
    hit_nxt      = hit_r;
    hit_slot_nxt = hit_slot_r;
    hit_auth_nxt = hit_auth_r;
    hit_rec_nxt  = hit_rec_r;
    emp_nxt      = emp_r;
    emp_slot_nxt = emp_slot_r;
    min_slot_nxt = min_slot_r;
    min_rec_nxt  = min_rec_r;
    tgt_nxt      = tgt_r;
    total_nxt    = total_r;
    lim_nxt      = lim_r;
    n_nxt        = n_r;
    prev_v_nxt   = prev_v_r;
    prev_nxt     = prev_r;
    best_v_nxt   = best_v_r;
    best_nxt     = best_r;
    pend_nxt     = pend_r;
    out_nxt      = out_r;
    out_v_nxt    = (out_v_r && out_tready) ? 1'b0 : out_v_r;

    unique case (state_r)
      lkpt_pkg::S_IDLE: begin
        if (in_acc) begin
          func_nxt  = lkpt_pkg::func_t'(in_tuser);
          key_nxt   = norm_key;
          auth_nxt  = in_tdata[lkpt_pkg::IN_W-1 -: lkpt_pkg::AUTH_W];
          hit_nxt   = 1'b0;
          emp_nxt   = 1'b0;
          total_nxt = '0;
          pend_nxt  = '{status: lkpt_pkg::ST_INVALID, slot: '0, key: '0, auth: '0,
                        rec: '0, last: 1'b1};
        end
      end
      lkpt_pkg::S_SCAN: begin
        if (head.key == key_r && !hit_r) begin
          hit_nxt      = 1'b1;
          hit_slot_nxt = head.slot;
          hit_auth_nxt = head.auth;
          hit_rec_nxt  = head.rec;
        end
        if (!head_valid && !emp_r) begin
          emp_nxt      = 1'b1;
          emp_slot_nxt = head.slot;
        end
        if (pos_r == '0 || head.rec < min_rec_r) begin
          min_slot_nxt = head.slot;
          min_rec_nxt  = head.rec;
        end
        if (pass_end) begin
          pend_nxt.status = lkpt_pkg::ST_OK;
          pend_nxt.key    = key_r;
          pend_nxt.last   = 1'b1;
          case (func_r)
            lkpt_pkg::FUNC_RECORD: begin
              tgt_nxt = hit_nxt ? hit_slot_nxt : (emp_nxt ? emp_slot_nxt : min_slot_nxt);
              cnt_nxt = cnt_r + 1'b1;
              pend_nxt.auth = auth_r;
              pend_nxt.rec  = cnt_nxt;
            end
            lkpt_pkg::FUNC_PROMOTE: begin
              tgt_nxt = hit_slot_nxt;
              cnt_nxt = hit_nxt ? cnt_r + 1'b1 : cnt_r;
              pend_nxt.auth = hit_auth_nxt;
              pend_nxt.rec  = cnt_nxt;
            end
            default: begin
              tgt_nxt = hit_slot_nxt;
              pend_nxt.auth = hit_auth_nxt;
              pend_nxt.rec  = hit_rec_nxt;
            end
          endcase
          pend_nxt.slot = 3'(tgt_nxt);
          if (func_r != lkpt_pkg::FUNC_RECORD && !hit_nxt) begin
            pend_nxt = '{status: lkpt_pkg::ST_NOT_FOUND, slot: '0, key: '0, auth: '0,
                         rec: '0, last: 1'b1};
          end
        end
      end
      lkpt_pkg::S_LCOUNT: begin
        if (head_valid) total_nxt = total_r + 1'b1;
        if (pass_end) begin
          lim_nxt    = (total_nxt > lkpt_pkg::CNT_W'(lkpt_pkg::LIST_MAX)) ?
                       lkpt_pkg::CNT_W'(lkpt_pkg::LIST_MAX) : total_nxt;
          n_nxt      = '0;
          prev_v_nxt = 1'b0;
          best_v_nxt = 1'b0;
          pend_nxt   = '{status: lkpt_pkg::ST_EMPTY, slot: '0, key: '0, auth: '0,
                         rec: '0, last: 1'b1};
        end
      end
      lkpt_pkg::S_LSEL: begin
        if (wb_valid && !wb.done && (!best_v_r || wb.rec > best_r.rec)) begin
          best_v_nxt = 1'b1;
          best_nxt   = wb;
        end
        if (pass_end) begin
          pend_nxt   = '{status: lkpt_pkg::ST_OK, slot: 3'(best_nxt.slot), key: best_nxt.key,
                         auth: best_nxt.auth, rec: best_nxt.rec,
                         last: (n_r + 1'b1 == lim_r)};
          prev_v_nxt = 1'b1;
          prev_nxt   = best_nxt.slot;
          n_nxt      = n_r + 1'b1;
          best_v_nxt = 1'b0;
        end
      end
      lkpt_pkg::S_EMIT: begin
        if (out_free) begin
          out_nxt   = pend_r;
          out_v_nxt = 1'b1;
        end
      end
      default: pend_nxt = pend_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= lkpt_pkg::S_IDLE;
      pos_r    <= '0;
      cnt_r    <= '0;
      out_v_r  <= 1'b0;
      hit_r    <= 1'b0;
      emp_r    <= 1'b0;
      prev_v_r <= 1'b0;
      best_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      cnt_r    <= cnt_nxt;
      out_v_r  <= out_v_nxt;
      hit_r    <= hit_nxt;
      emp_r    <= emp_nxt;
      prev_v_r <= prev_v_nxt;
      best_v_r <= best_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    key_r      <= key_nxt;
    auth_r     <= auth_nxt;
    hit_slot_r <= hit_slot_nxt;
    hit_auth_r <= hit_auth_nxt;
    hit_rec_r  <= hit_rec_nxt;
    emp_slot_r <= emp_slot_nxt;
    min_slot_r <= min_slot_nxt;
    min_rec_r  <= min_rec_nxt;
    tgt_r      <= tgt_nxt;
    total_r    <= total_nxt;
    lim_r      <= lim_nxt;
    n_r        <= n_nxt;
    prev_r     <= prev_nxt;
    best_r     <= best_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {3'b000, out_r.rec, out_r.auth, out_r.key, out_r.slot, out_r.status};

endmodule
`default_nettype wire
